@@ rtl/tss_pkg.sv @@
// Shared constants, types and helpers for the triangle span generator.
`default_nettype none
package tss_pkg;

   localparam int COORD_BITS = 12;
   localparam int MAX_ROWS   = 64;
   localparam int CNT_BITS   = $clog2(MAX_ROWS + 1);
   localparam int PROD_BITS  = 2 * COORD_BITS;
   localparam int STEP_BITS  = $clog2(PROD_BITS);
   localparam int SHADE_BITS = 8;
   localparam logic [SHADE_BITS-1:0] SHADE_RESET = 8'hFF;

   typedef logic signed [COORD_BITS-1:0]  coord_type;
   typedef logic signed [COORD_BITS:0]    diff_type;
   typedef logic        [COORD_BITS-1:0]  mag_type;
   typedef logic        [PROD_BITS-1:0]   prod_type;
   typedef logic signed [PROD_BITS+1:0]   sum_type;
   typedef logic        [CNT_BITS-1:0]    cnt_type;
   typedef logic        [STEP_BITS-1:0]   step_type;
   typedef logic        [SHADE_BITS-1:0]  shade_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic div_step;
      logic finish;
      logic next;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic div_done;
      logic last;
   } stat_type;

   function automatic mag_type mag(input diff_type d);
      logic [COORD_BITS:0] a;
      a = d[COORD_BITS] ? unsigned'(-d) : unsigned'(d);
      return a[COORD_BITS-1:0];
   endfunction

endpackage
`default_nettype wire

@@ rtl/tss_ifs.sv @@
// Handshake channels for triangle words and span words.
`default_nettype none
interface tss_req_if
   import tss_pkg::*;
   ();
   logic      valid;
   logic      ready;
   coord_type low_x;
   coord_type low_y;
   coord_type mid_x;
   coord_type mid_y;
   coord_type top_x;
   coord_type top_y;
   modport source (output valid, low_x, low_y, mid_x, mid_y, top_x, top_y, input ready);
   modport sink (input valid, low_x, low_y, mid_x, mid_y, top_x, top_y, output ready);
endinterface

interface tss_rsp_if
   import tss_pkg::*;
   ();
   logic      valid;
   logic      ready;
   coord_type row_y;
   coord_type long_edge_x;
   coord_type short_edge_x;
   shade_type shade_out;
   logic      last_span;
   logic      rows_cut;
   modport source (output valid, row_y, long_edge_x, short_edge_x, shade_out, last_span,
                   rows_cut, input ready);
   modport sink (input valid, row_y, long_edge_x, short_edge_x, shade_out, last_span,
                 rows_cut, output ready);
endinterface
`default_nettype wire

@@ rtl/triangle_scanline_spans.sv @@
// Top level of the triangle span generator: controller plus datapath.
//
// req_ch takes one triangle word (low, mid and top vertex, low_y <= top_y
// expected); rsp_ch returns one span word per row, top_y first, down to low_y.
// At most MAX_ROWS spans leave per triangle; rows_cut marks a clipped one and
// last_span marks the final span. A triangle with top_y below low_y yields no
// span; after its CHECK state the block returns to IDLE, ready again.
// csr_wr_en/csr_wr_data write the gray level carried on every span.
// Each span passes a setup step that multiplies the edge terms; then two
// restoring dividers produce one quotient bit each per cycle; then one step
// applies the sign, adds the vertex x and saturates into the output register,
// and a hand-off step holds the span until the receiver accepts it.
// A new triangle is taken only after the last span of the previous one is
// accepted.
// While rsp_ch.ready is low the span word holds and work pauses.
// Reset (synchronous) returns to idle, drops any pending spans and sets the
// gray level to 255.
`default_nettype none
module triangle_scanline_spans
   import tss_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   tss_req_if.sink    req_ch,
   tss_rsp_if.source  rsp_ch,
   input  wire logic  csr_wr_en,
   input  wire shade_type csr_wr_data
);

   cmd_type  cmd;
   stat_type stat;

   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tss_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .stat         (stat),
      .in_low_x     (req_ch.low_x),
      .in_low_y     (req_ch.low_y),
      .in_mid_x     (req_ch.mid_x),
      .in_mid_y     (req_ch.mid_y),
      .in_top_x     (req_ch.top_x),
      .in_top_y     (req_ch.top_y),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .row_y        (rsp_ch.row_y),
      .long_edge_x  (rsp_ch.long_edge_x),
      .short_edge_x (rsp_ch.short_edge_x),
      .shade_out    (rsp_ch.shade_out),
      .last_span    (rsp_ch.last_span),
      .rows_cut     (rsp_ch.rows_cut)
   );

endmodule
`default_nettype wire

@@ rtl/tss_ctrl.sv @@
// Sequencer for span setup, edge division and span hand-off.
`default_nettype none
module tss_ctrl
   import tss_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [5:0] {
      IDLE  = 6'b000001,
      CHECK = 6'b000010,
      MUL   = 6'b000100,
      DIV   = 6'b001000,
      FIN   = 6'b010000,
      SEND  = 6'b100000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= IDLE;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = CHECK;
            end
         end
         CHECK: state_in = stat.empty ? IDLE : MUL;
         MUL: begin
            cmd.mul  = 1'b1;
            state_in = DIV;
         end
         DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_done) state_in = FIN;
         end
         FIN: begin
            cmd.finish = 1'b1;
            state_in   = SEND;
         end
         SEND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               if (stat.last) begin
                  state_in = IDLE;
               end else begin
                  cmd.next = 1'b1;
                  state_in = MUL;
               end
            end
         end
         default: state_in = IDLE;
      endcase
   end

endmodule
`default_nettype wire

@@ rtl/tss_dpath.sv @@
// Vertex store, row counter, edge multipliers and restoring dividers.
`default_nettype none
module tss_dpath
   import tss_pkg::*;
(
   input  wire logic      clock,
   input  wire logic      reset,
   input  wire cmd_type   cmd,
   output stat_type       stat,
   input  wire coord_type in_low_x,
   input  wire coord_type in_low_y,
   input  wire coord_type in_mid_x,
   input  wire coord_type in_mid_y,
   input  wire coord_type in_top_x,
   input  wire coord_type in_top_y,
   input  wire logic      csr_wr_en,
   input  wire shade_type csr_wr_data,
   output coord_type      row_y,
   output coord_type      long_edge_x,
   output coord_type      short_edge_x,
   output shade_type      shade_out,
   output logic          last_span,
   output logic          rows_cut
);

   localparam sum_type SAT_MAX = sum_type'((1 <<< (COORD_BITS - 1)) - 1);
   localparam sum_type SAT_MIN = -sum_type'(1 <<< (COORD_BITS - 1));

   coord_type x0_ff, y0_ff, x1_ff, y1_ff, x2_ff, y2_ff, row_ff;
   cnt_type   left_ff;
   logic      cut_ff, empty_ff;
   shade_type gray_ff;
   step_type  step_ff;

   // edge 0 is low-top, edge 1 is the short edge for the current row
   prod_type  dvd_ff [2];
   mag_type   dvs_ff [2];
   mag_type   rem_ff [2];
   logic      neg_ff [2];
   logic      zero_ff[2];
   coord_type ax_ff  [2];

   // row count needs one bit more than a coordinate difference
   sum_type   total;
   diff_type  dx[2], dy[2], dt[2];
   coord_type ax[2];
   logic      upper;

   always_comb begin
      total = sum_type'(in_top_y) - sum_type'(in_low_y) + sum_type'(1);
      upper = row_ff > y1_ff;
      dx[0] = diff_type'(x2_ff) - diff_type'(x0_ff);
      dy[0] = diff_type'(y2_ff) - diff_type'(y0_ff);
      dt[0] = diff_type'(row_ff) - diff_type'(y2_ff);
      ax[0] = x2_ff;
      if (upper) begin
         dx[1] = diff_type'(x2_ff) - diff_type'(x1_ff);
         dy[1] = diff_type'(y2_ff) - diff_type'(y1_ff);
         dt[1] = diff_type'(row_ff) - diff_type'(y2_ff);
         ax[1] = x2_ff;
      end else begin
         dx[1] = diff_type'(x0_ff) - diff_type'(x1_ff);
         dy[1] = diff_type'(y0_ff) - diff_type'(y1_ff);
         dt[1] = diff_type'(row_ff) - diff_type'(y0_ff);
         ax[1] = x0_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) gray_ff <= SHADE_RESET;
      else if (csr_wr_en) gray_ff <= csr_wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x0_ff <= '0; y0_ff <= '0; x1_ff <= '0; y1_ff <= '0; x2_ff <= '0; y2_ff <= '0;
         row_ff <= '0; left_ff <= '0; cut_ff <= 1'b0; empty_ff <= 1'b0;
      end else if (cmd.load) begin
         x0_ff <= in_low_x; y0_ff <= in_low_y;
         x1_ff <= in_mid_x; y1_ff <= in_mid_y;
         x2_ff <= in_top_x; y2_ff <= in_top_y;
         row_ff   <= in_top_y;
         empty_ff <= in_top_y < in_low_y;
         cut_ff   <= total > sum_type'(MAX_ROWS);
         left_ff  <= (total > sum_type'(MAX_ROWS)) ? cnt_type'(MAX_ROWS)
                                                   : total[CNT_BITS-1:0];
      end else if (cmd.next) begin
         row_ff  <= row_ff - coord_type'(1);
         left_ff <= left_ff - cnt_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) step_ff <= '0;
      else if (cmd.mul) step_ff <= '0;
      else if (cmd.div_step) step_ff <= step_ff + step_type'(1);
   end

   for (genvar e = 0; e < 2; e++) begin : g_edge
      logic [COORD_BITS:0] rem_sh;
      logic                ge;
      logic [COORD_BITS:0] rem_sub;
      prod_type            quo;
      sum_type             sq, xs;
      coord_type           xo;

      always_comb begin
         rem_sh  = {rem_ff[e], dvd_ff[e][PROD_BITS-1]};
         ge      = rem_sh >= {1'b0, dvs_ff[e]};
         rem_sub = rem_sh - {1'b0, dvs_ff[e]};
         quo     = dvd_ff[e];
         sq      = neg_ff[e] ? -sum_type'({2'b00, quo}) : sum_type'({2'b00, quo});
         xs      = sum_type'(ax_ff[e]) + sq;
         if (zero_ff[e])      xo = ax_ff[e];
         else if (xs > SAT_MAX) xo = SAT_MAX[COORD_BITS-1:0];
         else if (xs < SAT_MIN) xo = SAT_MIN[COORD_BITS-1:0];
         else                 xo = xs[COORD_BITS-1:0];
      end

      always_ff @(posedge clock) begin
         if (cmd.mul) begin
            dvd_ff[e]  <= mag(dx[e]) * mag(dt[e]);
            dvs_ff[e]  <= mag(dy[e]);
            rem_ff[e]  <= '0;
            neg_ff[e]  <= dx[e][COORD_BITS] ^ dt[e][COORD_BITS] ^ dy[e][COORD_BITS];
            zero_ff[e] <= dy[e] == '0;
            ax_ff[e]   <= ax[e];
         end else if (cmd.div_step) begin
            // shift in next dividend bit, subtract where it fits
            rem_ff[e] <= ge ? rem_sub[COORD_BITS-1:0] : rem_sh[COORD_BITS-1:0];
            dvd_ff[e] <= {dvd_ff[e][PROD_BITS-2:0], ge};
         end
      end

      if (e == 0) begin : g_long
         always_ff @(posedge clock) begin
            if (cmd.finish) long_edge_x <= xo;
         end
      end else begin : g_short
         always_ff @(posedge clock) begin
            if (cmd.finish) short_edge_x <= xo;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         row_y     <= row_ff;
         shade_out <= gray_ff;
         last_span <= left_ff == cnt_type'(1);
         rows_cut  <= cut_ff;
      end
   end

   always_comb begin
      stat.empty    = empty_ff;
      stat.div_done = step_ff == step_type'(PROD_BITS - 1);
      stat.last     = left_ff == cnt_type'(1);
   end

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for the triangle span generator.
module tb;
   import tss_pkg::*;

   typedef struct {
      coord_type low_x, low_y, mid_x, mid_y, top_x, top_y;
   } tri_word;

   typedef struct {
      coord_type row_y, long_x, short_x;
      shade_type shade;
      logic      last, cut;
   } span_word;

   // a directed row: known marks rows whose spans are typed in below
   typedef struct {
      tri_word  t;
      bit       known;
      int       n_spans;
      span_word s;
   } stim_row;

   logic clock, reset;
   logic csr_wr_en;
   shade_type csr_wr_data;

   tss_req_if req_if ();
   tss_rsp_if rsp_if ();

   triangle_scanline_spans DUT (
      .clock(clock), .reset(reset), .req_ch(req_if), .rsp_ch(rsp_if),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   span_word  pending_spans[$];
   shade_type shade_reg;
   int        mismatches, spans_seen, tris_sent, tris_cut, tris_flipped;
   int        cycles;
   bit        calm;
   bit        holdoff_req;

   localparam int LIMIT = 3000000;

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("Verification failed");
         $finish;
      end
   end

   function automatic longint edge_at(longint ax, longint ay, longint dx, longint dy,
                                      longint row);
      longint r;
      if (dy == 0) r = ax;
      else r = ax + (dx * (row - ay)) / dy;
      if (r < -2048) r = -2048;
      if (r > 2047) r = 2047;
      return r;
   endfunction

   // expand one triangle into its expected spans
   task automatic predict_spans(tri_word t);
      longint x0, y0, x1, y1, x2, y2, total, count, row, xl, xs;
      bit cut;
      span_word s;
      x0 = t.low_x; y0 = t.low_y; x1 = t.mid_x;
      y1 = t.mid_y; x2 = t.top_x; y2 = t.top_y;
      if (y2 < y0) begin
         tris_flipped++;
         return;
      end
      total = y2 - y0 + 1;
      cut = total > MAX_ROWS;
      count = cut ? MAX_ROWS : total;
      if (cut) tris_cut++;
      for (longint k = 0; k < count; k++) begin
         row = y2 - k;
         xl = edge_at(x2, y2, x2 - x0, y2 - y0, row);
         if (row > y1) xs = edge_at(x2, y2, x2 - x1, y2 - y1, row);
         else xs = edge_at(x0, y0, x0 - x1, y0 - y1, row);
         s.row_y = row[11:0];
         s.long_x = xl[11:0];
         s.short_x = xs[11:0];
         s.shade = shade_reg;
         s.last = (k == count - 1);
         s.cut = cut;
         pending_spans.push_back(s);
      end
   endtask

   // send one triangle; leaves valid high after acceptance
   task automatic send_tri(tri_word t);
      @(negedge clock);
      while (!calm && $urandom_range(99) < 30) begin
         req_if.valid = 0;
         @(negedge clock);
      end
      req_if.valid = 1;
      req_if.low_x = t.low_x; req_if.low_y = t.low_y;
      req_if.mid_x = t.mid_x; req_if.mid_y = t.mid_y;
      req_if.top_x = t.top_x; req_if.top_y = t.top_y;
      do @(posedge clock); while (!req_if.ready);
      tris_sent++;
   endtask

   task automatic write_shade(shade_type v);
      @(negedge clock);
      req_if.valid = 0;
      while (pending_spans.size() != 0) @(negedge clock);
      // an inverted triangle may still be in flight with nothing expected
      repeat (40) @(negedge clock);
      csr_wr_en = 1;
      csr_wr_data = v;
      @(negedge clock);
      csr_wr_en = 0;
      shade_reg = v;
   endtask

   function automatic tri_word rand_tri();
      tri_word t;
      int h, lo, sel;
      sel = $urandom_range(99);
      if (sel < 4) h = -$urandom_range(1, 300);
      else if (sel < 9) h = $urandom_range(60, 70);
      else if (sel < 11) h = $urandom_range(71, 4095);
      else h = $urandom_range(0, 12);
      lo = int'($urandom_range(4095)) - 2048;
      if (lo + h > 2047) lo = 2047 - h;
      if (lo + h < -2048) lo = -2048 - h;
      t.low_y = lo;
      t.top_y = lo + h;
      t.low_x = $urandom;
      t.mid_x = $urandom;
      t.top_x = $urandom;
      if ($urandom_range(99) < 85 && h >= 0) t.mid_y = lo + int'($urandom_range(h));
      else t.mid_y = $urandom;
      if ($urandom_range(99) < 60) begin
         // keep x near the low vertex so spans stay on screen
         t.mid_x = t.low_x + int'($urandom_range(200)) - 100;
         t.top_x = t.low_x + int'($urandom_range(200)) - 100;
      end
      return t;
   endfunction

   // sink side: random stalls, one long hold-off on request
   initial begin
      int hold;
      rsp_if.ready = 0;
      hold = 0;
      forever begin
         @(negedge clock);
         if (holdoff_req && hold == 0) begin
            hold = 500;
            holdoff_req = 0;
         end
         if (hold > 0) begin
            hold--;
            rsp_if.ready = 0;
         end else rsp_if.ready = calm || ($urandom_range(99) >= 30);
      end
   end

   always @(posedge clock) begin
      span_word e;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         spans_seen++;
         if (pending_spans.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected span row %0d", rsp_if.row_y);
         end else begin
            e = pending_spans.pop_front();
            if (rsp_if.row_y !== e.row_y || rsp_if.long_edge_x !== e.long_x ||
                rsp_if.short_edge_x !== e.short_x || rsp_if.shade_out !== e.shade ||
                rsp_if.last_span !== e.last || rsp_if.rows_cut !== e.cut) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("span mismatch: exp row %0d long %0d short %0d shade %0d last %b cut %b, got row %0d long %0d short %0d shade %0d last %b cut %b",
                     e.row_y, e.long_x, e.short_x, e.shade, e.last, e.cut,
                     rsp_if.row_y, rsp_if.long_edge_x, rsp_if.short_edge_x,
                     rsp_if.shade_out, rsp_if.last_span, rsp_if.rows_cut);
            end
         end
      end
   end

   function automatic stim_row mk(int lx, int ly, int mx, int my, int tx, int ty);
      stim_row r;
      r.t.low_x = lx; r.t.low_y = ly; r.t.mid_x = mx;
      r.t.mid_y = my; r.t.top_x = tx; r.t.top_y = ty;
      r.known = 0;
      r.n_spans = 0;
      return r;
   endfunction

   function automatic stim_row mk_point(int x, int y);
      stim_row r;
      r = mk(x, y, x, y, x, y);
      r.known = 1;
      r.n_spans = 1;
      r.s.row_y = y; r.s.long_x = x; r.s.short_x = x;
      r.s.shade = SHADE_RESET; r.s.last = 1; r.s.cut = 0;
      return r;
   endfunction

   initial begin
      stim_row table_rows[$];
      stim_row r;
      reset = 1;
      csr_wr_en = 0;
      csr_wr_data = 0;
      req_if.valid = 0;
      req_if.low_x = 0; req_if.low_y = 0; req_if.mid_x = 0;
      req_if.mid_y = 0; req_if.top_x = 0; req_if.top_y = 0;
      shade_reg = SHADE_RESET;
      cycles = 0;
      calm = 0;
      holdoff_req = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 0;

      table_rows.push_back(mk_point(0, 0));
      table_rows.push_back(mk_point(-2048, -2048));
      table_rows.push_back(mk_point(2047, 2047));
      r = mk(1, 5, 2, 5, 3, 4);          // top below low: nothing
      r.known = 1;
      table_rows.push_back(r);
      r = mk(-2048, 2047, 0, 0, 2047, -2048);
      r.known = 1;
      table_rows.push_back(r);
      table_rows.push_back(mk(0, 0, 10, 9, -10, 9));        // flat top
      table_rows.push_back(mk(0, 0, 12, 0, 5, 11));         // flat bottom
      table_rows.push_back(mk(-7, -3, 20, 2, 4, 8));
      table_rows.push_back(mk(100, 0, -100, 30, 0, 63));    // exactly the row limit
      table_rows.push_back(mk(100, 0, -100, 30, 0, 64));    // one row too many
      table_rows.push_back(mk(-2048, -2048, 2047, 0, 2047, 2047));
      table_rows.push_back(mk(0, 0, 2047, 2047, -2048, 10)); // mid above top
      table_rows.push_back(mk(0, 0, -2048, -2048, 2047, 10));// mid below low
      table_rows.push_back(mk(0, 0, 2047, 1, -2048, 40));    // steep short edge
      table_rows.push_back(mk(2047, -5, -2048, -4, 2047, 5));

      foreach (table_rows[i]) begin
         send_tri(table_rows[i].t);
         if (table_rows[i].known) begin
            if (table_rows[i].n_spans == 0) tris_flipped++;
            else pending_spans.push_back(table_rows[i].s);
         end else predict_spans(table_rows[i].t);
      end

      for (int phase = 0; phase < 5; phase++) begin
         case (phase)
            0: write_shade(8'h00);
            1: write_shade(8'hFF);
            2: write_shade(8'h01);
            3: write_shade(shade_type'($urandom));
            default: write_shade(8'h80);
         endcase
         calm = (phase == 3);
         if (phase == 2) holdoff_req = 1;
         for (int n = 0; n < 70; n++) begin
            tri_word t;
            t = rand_tri();
            send_tri(t);
            predict_spans(t);
         end
      end
      calm = 0;

      @(negedge clock);
      req_if.valid = 0;
      while (pending_spans.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      $display("%0d triangles sent (%0d inverted, %0d clipped), %0d spans checked",
               tris_sent, tris_flipped, tris_cut, spans_seen);
      $display("gray level swept over 0, 1, 128, 255 and a random value");
      if (mismatches == 0 && pending_spans.size() == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end
endmodule
